@@ src/bfsgd_pkg.sv @@
// Shared types, codes and saturation helper for the biased factor SGD block.
package bfsgd_pkg;

   // Operation codes of an input item.
   localparam logic [1:0] OP_LOAD_USER = 2'd0;
   localparam logic [1:0] OP_LOAD_ITEM = 2'd1;
   localparam logic [1:0] OP_TRAIN     = 2'd2;
   localparam logic [1:0] OP_PREDICT   = 2'd3;

   // Register indexes on the configuration port (byte address bits 3:2).
   localparam logic [1:0] REG_MEAN = 2'd0;
   localparam logic [1:0] REG_RATE = 2'd1;
   localparam logic [1:0] REG_LAMBDA = 2'd2;

   // Register reset values.
   localparam logic [15:0] RESET_RATE   = 16'd1311;
   localparam logic [15:0] RESET_LAMBDA = 16'd655;

   typedef logic [1:0] op_type;
   typedef logic signed [31:0] word_type;

   // Clip a wide signed value into 32 bits; bit 32 of the result flags a clip.
   function automatic logic [32:0] sat32(input logic signed [67:0] v);
      logic [32:0] r;
      if (v > 68'sh0_0000_0000_7FFF_FFFF) begin
         r = {1'b1, 32'h7FFF_FFFF};
      end else if (v < -68'sh0_0000_0000_8000_0000) begin
         r = {1'b1, 32'h8000_0000};
      end else begin
         r = {1'b0, v[31:0]};
      end
      return r;
   endfunction

endpackage

@@ src/bfsgd_req_if.sv @@
// Input channel carrying one train, predict or load item.
interface bfsgd_req_if;
   logic                     valid;
   logic                     ready;
   bfsgd_pkg::op_type        operation;
   logic [9:0]               user_index;
   logic [9:0]               item_index;
   logic [3:0]               factor_index;
   bfsgd_pkg::word_type      load_value;
   logic [3:0]               rating;

   modport source(output valid, operation, user_index, item_index, factor_index,
                  load_value, rating, input ready);
   modport sink(input valid, operation, user_index, item_index, factor_index,
                load_value, rating, output ready);
endinterface

@@ src/bfsgd_rsp_if.sv @@
// Result channel carrying the prediction, error and saturation flag.
interface bfsgd_rsp_if;
   logic                valid;
   logic                ready;
   bfsgd_pkg::word_type prediction;
   bfsgd_pkg::word_type error;
   logic                saturated;

   modport source(output valid, prediction, error, saturated, input ready);
   modport sink(input valid, prediction, error, saturated, output ready);
endinterface

@@ src/bfsgd_mul.sv @@
// Shared signed multiplier with a registered product.
module bfsgd_mul (
   input  logic                clock,
   input  logic signed [33:0]  mul_a,
   input  logic signed [32:0]  mul_b,
   output logic signed [66:0]  prod_ff
);

   logic signed [66:0] prod_in;

   // One product per cycle, registered before anyone uses it.
   assign prod_in = 67'(mul_a) * 67'(mul_b);

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

endmodule

@@ src/biased_factor_sgd_update.sv @@
// Biased matrix factorization SGD engine: factor and bias tables, one shared multiplier.
// Only one item is in flight: a new item is accepted only when the last result has been taken.
// Every product goes through the single multiplier, three steps per element for the dot
// product and eight per element for the update.
// After reset the bias tables are cleared, one entry a cycle, over indexes 0 to
// max(NUM_USERS, NUM_ITEMS) - 1, during which no item is accepted; configuration
// writes are taken as ever.
module biased_factor_sgd_update #(
   parameter int NUM_USERS = 1024,
   parameter int NUM_ITEMS = 1024,
   parameter int FACTORS   = 16,
   parameter int FRAC_BITS = 16
) (
   input  logic               clock,
   input  logic               reset,
   bfsgd_req_if.sink          req,
   bfsgd_rsp_if.source        rsp,
   input  logic               csr_psel,
   input  logic               csr_penable,
   input  logic               csr_pwrite,
   input  logic [3:0]         csr_paddr,
   input  logic [31:0]        csr_pwdata,
   output logic [31:0]        csr_prdata,
   output logic               csr_pready
);

   localparam int UW   = $clog2(NUM_USERS);
   localparam int IW   = $clog2(NUM_ITEMS);
   localparam int UAW  = $clog2(NUM_USERS * FACTORS);
   localparam int IAW  = $clog2(NUM_ITEMS * FACTORS);
   localparam int FW   = (FACTORS > 1) ? $clog2(FACTORS) : 1;
   localparam int MAXN = (NUM_USERS > NUM_ITEMS) ? NUM_USERS : NUM_ITEMS;
   localparam int CW   = $clog2(MAXN);

   // Sequencer states.
   localparam logic [4:0] S_CLEAR = 5'd0;
   localparam logic [4:0] S_IDLE  = 5'd1;
   localparam logic [4:0] S_BRD   = 5'd2;
   localparam logic [4:0] S_BDAT  = 5'd3;
   localparam logic [4:0] S_DRD   = 5'd4;
   localparam logic [4:0] S_DMUL  = 5'd5;
   localparam logic [4:0] S_DACC  = 5'd6;
   localparam logic [4:0] S_PRED  = 5'd7;
   localparam logic [4:0] S_B0    = 5'd8;
   localparam logic [4:0] S_B1    = 5'd9;
   localparam logic [4:0] S_B2    = 5'd10;
   localparam logic [4:0] S_B3    = 5'd11;
   localparam logic [4:0] S_B4    = 5'd12;
   localparam logic [4:0] S_U0    = 5'd13;
   localparam logic [4:0] S_U1    = 5'd14;
   localparam logic [4:0] S_U2    = 5'd15;
   localparam logic [4:0] S_U3    = 5'd16;
   localparam logic [4:0] S_U4    = 5'd17;
   localparam logic [4:0] S_U5    = 5'd18;
   localparam logic [4:0] S_U6    = 5'd19;
   localparam logic [4:0] S_U7    = 5'd20;
   localparam logic [4:0] S_RESP  = 5'd21;

   // Reduce a 10-bit row index modulo the table depth by conditional subtraction.
   function automatic int wrap_index(input logic [9:0] x, input int n);
      int r;
      r = int'(x);
      for (int k = 9; k >= 0; k--) begin
         if (r >= (n << k)) begin
            r = r - (n << k);
         end
      end
      return r;
   endfunction

   // Tables.
   bfsgd_pkg::word_type umem [NUM_USERS*FACTORS];
   bfsgd_pkg::word_type imem [NUM_ITEMS*FACTORS];
   bfsgd_pkg::word_type ubmem [NUM_USERS];
   bfsgd_pkg::word_type ibmem [NUM_ITEMS];

   // Sequencer and datapath registers.
   logic [4:0]              state_ff, state_in;
   logic [FW-1:0]           f_ff, f_in;
   logic [CW-1:0]           clr_ff, clr_in;
   bfsgd_pkg::op_type       op_ff, op_in;
   logic [UW-1:0]           uidx_ff, uidx_in;
   logic [IW-1:0]           iidx_ff, iidx_in;
   logic [UAW-1:0]          ubase_ff, ubase_in;
   logic [IAW-1:0]          ibase_ff, ibase_in;
   logic [3:0]              rating_ff, rating_in;
   logic signed [63:0]      acc_ff, acc_in;
   logic signed [63:0]      t_ff, t_in;
   logic signed [33:0]      g_ff, g_in, g2_ff, g2_in;
   bfsgd_pkg::word_type     pred_ff, pred_in, err_ff, err_in;
   bfsgd_pkg::word_type     bu_ff, bu_in, bi_ff, bi_in;
   bfsgd_pkg::word_type     p_ff, p_in, q_ff, q_in;
   bfsgd_pkg::word_type     gp_ff, gp_in, gq_ff, gq_in;
   logic                    sat_ff, sat_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [19:0]             mean_ff, mean_in;
   logic [15:0]             rate_ff, rate_in;
   logic [15:0]             lam_ff, lam_in;

   // Memory read registers.
   bfsgd_pkg::word_type     urd_ff, ird_ff, ubrd_ff, ibrd_ff;

   // Memory control.
   logic                    fac_re, ufac_we, ifac_we, b_re, ub_we, ib_we;
   logic [UAW-1:0]          fac_uaddr;
   logic [IAW-1:0]          fac_iaddr;
   logic [UW-1:0]           ub_addr;
   logic [IW-1:0]           ib_addr;
   bfsgd_pkg::word_type     ufac_wd, ifac_wd, ub_wd, ib_wd;

   // Shared multiplier.
   logic signed [33:0]      mul_a;
   logic signed [32:0]      mul_b;
   logic signed [66:0]      prod_ff;
   logic signed [66:0]      prod_f, prod_16;

   logic                    accept;
   logic                    csr_wr;
   logic signed [32:0]      alpha_c, lambda_c;

   bfsgd_mul u_bfsgd_mul (
      .clock  (clock),
      .mul_a  (mul_a),
      .mul_b  (mul_b),
      .prod_ff(prod_ff)
   );

   assign req.ready      = (state_ff == S_IDLE);
   assign accept         = req.valid && (state_ff == S_IDLE);
   assign rsp.valid      = rsp_valid_ff;
   assign rsp.prediction = pred_ff;
   assign rsp.error      = err_ff;
   assign rsp.saturated  = sat_ff;

   assign prod_f   = prod_ff >>> FRAC_BITS;
   assign prod_16  = prod_ff >>> 16;
   assign alpha_c  = $signed({17'd0, rate_ff});
   assign lambda_c = $signed({17'd0, lam_ff});

   // Configuration port: writes complete in the access phase, reads are combinational.
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;

   always_comb begin
      mean_in = mean_ff;
      rate_in = rate_ff;
      lam_in  = lam_ff;
      if (csr_wr) begin
         case (csr_paddr[3:2])
            bfsgd_pkg::REG_MEAN:   mean_in = csr_pwdata[19:0];
            bfsgd_pkg::REG_RATE:   rate_in = csr_pwdata[15:0];
            bfsgd_pkg::REG_LAMBDA: lam_in  = csr_pwdata[15:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[3:2])
         bfsgd_pkg::REG_MEAN:   csr_prdata = {12'd0, mean_ff};
         bfsgd_pkg::REG_RATE:   csr_prdata = {16'd0, rate_ff};
         bfsgd_pkg::REG_LAMBDA: csr_prdata = {16'd0, lam_ff};
         default:               csr_prdata = 32'd0;
      endcase
   end

   // Sequencer and datapath.
   always_comb begin
      logic [32:0] s_a;
      logic [32:0] s_b;
      s_a          = '0;
      s_b          = '0;
      state_in     = state_ff;
      f_in         = f_ff;
      clr_in       = clr_ff;
      op_in        = op_ff;
      uidx_in      = uidx_ff;
      iidx_in      = iidx_ff;
      ubase_in     = ubase_ff;
      ibase_in     = ibase_ff;
      rating_in    = rating_ff;
      acc_in       = acc_ff;
      t_in         = t_ff;
      g_in         = g_ff;
      g2_in        = g2_ff;
      pred_in      = pred_ff;
      err_in       = err_ff;
      bu_in        = bu_ff;
      bi_in        = bi_ff;
      p_in         = p_ff;
      q_in         = q_ff;
      gp_in        = gp_ff;
      gq_in        = gq_ff;
      sat_in       = sat_ff;
      rsp_valid_in = rsp_valid_ff;
      fac_re       = 1'b0;
      ufac_we      = 1'b0;
      ifac_we      = 1'b0;
      b_re         = 1'b0;
      ub_we        = 1'b0;
      ib_we        = 1'b0;
      fac_uaddr    = ubase_ff + UAW'(f_ff);
      fac_iaddr    = ibase_ff + IAW'(f_ff);
      ub_addr      = uidx_ff;
      ib_addr      = iidx_ff;
      ufac_wd      = req.load_value;
      ifac_wd      = req.load_value;
      ub_wd        = '0;
      ib_wd        = '0;
      mul_a        = '0;
      mul_b        = '0;

      unique case (state_ff)
         // Zero the bias tables after reset.
         S_CLEAR: begin
            ub_addr = clr_ff[UW-1:0];
            ib_addr = clr_ff[IW-1:0];
            ub_we   = int'(clr_ff) < NUM_USERS;
            ib_we   = int'(clr_ff) < NUM_ITEMS;
            clr_in  = CW'(int'(clr_ff) + 1);
            if (int'(clr_ff) == MAXN - 1) begin
               state_in = S_IDLE;
            end
         end

         // Take an item; loads write their element at once.
         S_IDLE: begin
            fac_uaddr = UAW'(wrap_index(req.user_index, NUM_USERS) * FACTORS
                             + int'(req.factor_index));
            fac_iaddr = IAW'(wrap_index(req.item_index, NUM_ITEMS) * FACTORS
                             + int'(req.factor_index));
            if (accept) begin
               op_in     = req.operation;
               uidx_in   = UW'(wrap_index(req.user_index, NUM_USERS));
               iidx_in   = IW'(wrap_index(req.item_index, NUM_ITEMS));
               ubase_in  = UAW'(wrap_index(req.user_index, NUM_USERS) * FACTORS);
               ibase_in  = IAW'(wrap_index(req.item_index, NUM_ITEMS) * FACTORS);
               rating_in = req.rating;
               sat_in    = 1'b0;
               pred_in   = '0;
               err_in    = '0;
               f_in      = '0;
               if (req.operation == bfsgd_pkg::OP_LOAD_USER ||
                   req.operation == bfsgd_pkg::OP_LOAD_ITEM) begin
                  ufac_we = (req.operation == bfsgd_pkg::OP_LOAD_USER) &&
                            (int'(req.factor_index) < FACTORS);
                  ifac_we = (req.operation == bfsgd_pkg::OP_LOAD_ITEM) &&
                            (int'(req.factor_index) < FACTORS);
                  rsp_valid_in = 1'b1;
                  state_in     = S_RESP;
               end else begin
                  state_in = S_BRD;
               end
            end
         end

         S_BRD: begin
            b_re     = 1'b1;
            state_in = S_BDAT;
         end

         // Start the sum with the mean and both biases.
         S_BDAT: begin
            bu_in    = ubrd_ff;
            bi_in    = ibrd_ff;
            acc_in   = $signed({44'd0, mean_ff}) + 64'(ubrd_ff) + 64'(ibrd_ff);
            state_in = S_DRD;
         end

         // Dot product: read both factors, multiply, then accumulate, for each element.
         S_DRD: begin
            fac_re   = 1'b1;
            state_in = S_DMUL;
         end

         S_DMUL: begin
            mul_a    = 34'(urd_ff);
            mul_b    = 33'(ird_ff);
            state_in = S_DACC;
         end

         S_DACC: begin
            acc_in = acc_ff + 64'(prod_f);
            if (f_ff == FW'(FACTORS - 1)) begin
               f_in     = '0;
               state_in = S_PRED;
            end else begin
               f_in     = FW'(int'(f_ff) + 1);
               state_in = S_DRD;
            end
         end

         // Clip the prediction and form the error for training.
         S_PRED: begin
            s_a     = bfsgd_pkg::sat32(68'(acc_ff));
            pred_in = s_a[31:0];
            if (op_ff == bfsgd_pkg::OP_PREDICT) begin
               sat_in       = sat_ff | s_a[32];
               rsp_valid_in = 1'b1;
               state_in     = S_RESP;
            end else begin
               s_b = bfsgd_pkg::sat32(($signed({64'd0, rating_ff}) <<< FRAC_BITS)
                                      - 68'($signed(s_a[31:0])));
               err_in   = s_b[31:0];
               sat_in   = sat_ff | s_a[32] | s_b[32];
               state_in = S_B0;
            end
         end

         // Bias updates.
         S_B0: begin
            mul_a    = 34'(bu_ff);
            mul_b    = lambda_c;
            state_in = S_B1;
         end

         S_B1: begin
            g_in     = 34'(err_ff) - 34'(prod_16);
            mul_a    = 34'(bi_ff);
            mul_b    = lambda_c;
            state_in = S_B2;
         end

         S_B2: begin
            g2_in    = 34'(err_ff) - 34'(prod_16);
            mul_a    = g_ff;
            mul_b    = alpha_c;
            state_in = S_B3;
         end

         S_B3: begin
            s_a      = bfsgd_pkg::sat32(68'(bu_ff) + 68'(prod_16));
            ub_wd    = s_a[31:0];
            ub_we    = 1'b1;
            sat_in   = sat_ff | s_a[32];
            mul_a    = g2_ff;
            mul_b    = alpha_c;
            state_in = S_B4;
         end

         S_B4: begin
            s_a      = bfsgd_pkg::sat32(68'(bi_ff) + 68'(prod_16));
            ib_wd    = s_a[31:0];
            ib_we    = 1'b1;
            sat_in   = sat_ff | s_a[32];
            f_in     = '0;
            state_in = S_U0;
         end

         // Factor updates from the values held before the step.
         S_U0: begin
            fac_re   = 1'b1;
            state_in = S_U1;
         end

         S_U1: begin
            p_in     = urd_ff;
            q_in     = ird_ff;
            mul_a    = 34'(ird_ff);
            mul_b    = 33'(err_ff);
            state_in = S_U2;
         end

         S_U2: begin
            t_in     = 64'(prod_f);
            mul_a    = 34'(p_ff);
            mul_b    = lambda_c;
            state_in = S_U3;
         end

         S_U3: begin
            s_a      = bfsgd_pkg::sat32(68'(t_ff) - 68'(prod_16));
            gp_in    = s_a[31:0];
            sat_in   = sat_ff | s_a[32];
            mul_a    = 34'(p_ff);
            mul_b    = 33'(err_ff);
            state_in = S_U4;
         end

         S_U4: begin
            t_in     = 64'(prod_f);
            mul_a    = 34'(q_ff);
            mul_b    = lambda_c;
            state_in = S_U5;
         end

         S_U5: begin
            s_a      = bfsgd_pkg::sat32(68'(t_ff) - 68'(prod_16));
            gq_in    = s_a[31:0];
            sat_in   = sat_ff | s_a[32];
            mul_a    = 34'(gp_ff);
            mul_b    = alpha_c;
            state_in = S_U6;
         end

         S_U6: begin
            s_a      = bfsgd_pkg::sat32(68'(p_ff) + 68'(prod_16));
            ufac_wd  = s_a[31:0];
            ufac_we  = 1'b1;
            sat_in   = sat_ff | s_a[32];
            mul_a    = 34'(gq_ff);
            mul_b    = alpha_c;
            state_in = S_U7;
         end

         S_U7: begin
            s_a     = bfsgd_pkg::sat32(68'(q_ff) + 68'(prod_16));
            ifac_wd = s_a[31:0];
            ifac_we = 1'b1;
            sat_in  = sat_ff | s_a[32];
            if (f_ff == FW'(FACTORS - 1)) begin
               rsp_valid_in = 1'b1;
               state_in     = S_RESP;
            end else begin
               f_in     = FW'(int'(f_ff) + 1);
               state_in = S_U0;
            end
         end

         // Hold the result until it is taken.
         S_RESP: begin
            if (rsp.ready) begin
               rsp_valid_in = 1'b0;
               state_in     = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         mean_ff      <= '0;
         rate_ff      <= bfsgd_pkg::RESET_RATE;
         lam_ff       <= bfsgd_pkg::RESET_LAMBDA;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
         mean_ff      <= mean_in;
         rate_ff      <= rate_in;
         lam_ff       <= lam_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      f_ff      <= f_in;
      op_ff     <= op_in;
      uidx_ff   <= uidx_in;
      iidx_ff   <= iidx_in;
      ubase_ff  <= ubase_in;
      ibase_ff  <= ibase_in;
      rating_ff <= rating_in;
      acc_ff    <= acc_in;
      t_ff      <= t_in;
      g_ff      <= g_in;
      g2_ff     <= g2_in;
      pred_ff   <= pred_in;
      err_ff    <= err_in;
      bu_ff     <= bu_in;
      bi_ff     <= bi_in;
      p_ff      <= p_in;
      q_ff      <= q_in;
      gp_ff     <= gp_in;
      gq_ff     <= gq_in;
      sat_ff    <= sat_in;
   end

   // Factor tables: one address per table, registered read.
   always_ff @(posedge clock) begin
      if (ufac_we) begin
         umem[fac_uaddr] <= ufac_wd;
      end
      if (fac_re) begin
         urd_ff <= umem[fac_uaddr];
      end
   end

   always_ff @(posedge clock) begin
      if (ifac_we) begin
         imem[fac_iaddr] <= ifac_wd;
      end
      if (fac_re) begin
         ird_ff <= imem[fac_iaddr];
      end
   end

   // Bias tables: one address per table, registered read.
   always_ff @(posedge clock) begin
      if (ub_we) begin
         ubmem[ub_addr] <= ub_wd;
      end
      if (b_re) begin
         ubrd_ff <= ubmem[ub_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (ib_we) begin
         ibmem[ib_addr] <= ib_wd;
      end
      if (b_re) begin
         ibrd_ff <= ibmem[ib_addr];
      end
   end

endmodule

@@ src/bfsgd_checker.sv @@
// Port-level checks for the biased factor SGD block and their binding.
module bfsgd_checker (
   input logic                clock,
   input logic                reset,
   input logic                req_valid,
   input logic                req_ready,
   input logic                rsp_valid,
   input logic                rsp_ready,
   input bfsgd_pkg::word_type rsp_prediction,
   input bfsgd_pkg::word_type rsp_error,
   input logic                rsp_saturated
);

   // A stalled result keeps its payload.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_prediction) &&
      $stable(rsp_error) && $stable(rsp_saturated))
      else $error("result changed while stalled");

   // Only one item is in flight: no input is taken while a result waits.
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready)
      else $error("input ready while a result waits");

   // After an item is taken, input is not ready in the following cycle.
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("input ready right after acceptance");

   // Reset starts the clearing pass with nothing pending.
   a_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_ready)
      else $error("block not quiet after reset");

endmodule

bind biased_factor_sgd_update bfsgd_checker u_bfsgd_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req.valid),
   .req_ready     (req.ready),
   .rsp_valid     (rsp.valid),
   .rsp_ready     (rsp.ready),
   .rsp_prediction(rsp.prediction),
   .rsp_error     (rsp.error),
   .rsp_saturated (rsp.saturated)
);
